// ----- hdl/ptlw_pkg.sv -----
package ptlw_pkg;

    localparam int STORE_WORDS_DEF = 4096;

    localparam int VA_W    = 48;
    localparam int DESC_W  = 64;
    localparam int LEVEL_W = 2;
    localparam int SLICE_W = 9;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IA_BITS     = 2'd0,
        CFG_FIRST_LEVEL = 2'd1,
        CFG_ROOT_BASE   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef struct packed {
        logic        opcode;
        logic [11:0] word_index;
        logic [63:0] word_value;
        logic [47:0] lookup_address;
    } ptlw_in_t;

    typedef struct packed {
        logic [63:0] leaf_descriptor;
        logic [1:0]  leaf_level;
    } ptlw_out_t;

    // controller -> datapath
    typedef struct packed {
        logic store_wr;   // write the item's word into the store
        logic start;      // latch lookup address, set up root table
        logic read_root;  // read entry of the root table
        logic read_next;  // follow current descriptor, read next level
        logic out_load;   // load result register
    } ptlw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic follow;     // descriptor just read points to a next table
        logic out_busy;   // result register full and not taken this cycle
    } ptlw_sts_t;

    // 9-bit table index of an address for a given level
    function automatic logic [SLICE_W-1:0] level_slice(input logic [VA_W-1:0] va,
                                                       input logic [LEVEL_W-1:0] lvl);
        logic [SLICE_W-1:0] s;
        case (lvl)
            2'd0:    s = va[47:39];
            2'd1:    s = va[38:30];
            2'd2:    s = va[29:21];
            default: s = va[20:12];
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/ptlw_ctrl.sv -----
module ptlw_ctrl
    import ptlw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_opcode,
    output logic      s_ready,
    input  ptlw_sts_t sts,
    output ptlw_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == OP_LOOKUP) begin
                        cmd.start  = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        cmd.store_wr = 1'b1;
                    end
                end
            end
            ST_READ: begin
                cmd.read_root = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.follow) begin
                    cmd.read_next = 1'b1;
                end else if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/ptlw_datapath.sv -----
module ptlw_datapath
    import ptlw_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  ptlw_in_t             s_payload,
    input  ptlw_cmd_t            cmd,
    output ptlw_sts_t            sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ptlw_out_t            m_payload
);

    localparam int ADDR_W = $clog2(STORE_WORDS);

    // config
    logic [5:0]         ia_bits_reg;
    logic [LEVEL_W-1:0] first_level_reg;
    logic [VA_W-1:0]    root_base_reg;

    // walk state
    logic [VA_W-1:0]    va_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [DESC_W-1:0]  rd_data_reg;
    logic               out_valid_reg;
    ptlw_out_t          out_reg;

    logic [DESC_W-1:0]  store_mem [STORE_WORDS];

    logic [VA_W-1:0]    va_in;
    logic [VA_W-1:0]    ia_mask;
    logic [VA_W-1:0]    va_masked;
    logic [VA_W-1:0]    root_idx;
    logic [VA_W-1:0]    root_off;
    logic [ADDR_W-1:0]  root_word;
    logic [VA_W-1:0]    next_tbl;
    logic [LEVEL_W-1:0] level_inc;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  wr_addr;

    // root table selection, from the item's address
    always_comb begin
        va_in = {s_payload.lookup_address[47:12], 12'd0};
        if (ia_bits_reg >= 6'd48) begin
            ia_mask = '1;
        end else begin
            ia_mask = (VA_W'(1) << ia_bits_reg) - VA_W'(1);
        end
        va_masked = va_in & ia_mask;
        case (first_level_reg)
            2'd0:    root_idx = '0;
            2'd1:    root_idx = va_masked >> 39;
            2'd2:    root_idx = va_masked >> 30;
            default: root_idx = va_masked >> 21;
        endcase
        root_off  = root_idx << SLICE_W;
        root_word = root_base_reg[ADDR_W+2:3] + root_off[ADDR_W-1:0];
    end

    // store addressing
    assign level_inc = level_reg + 2'd1;
    assign next_tbl  = {rd_data_reg[47:12], 12'd0} >> 3;
    assign rd_en     = cmd.read_root | cmd.read_next;
    assign wr_addr   = ADDR_W'(s_payload.word_index);

    always_comb begin
        if (cmd.read_next) begin
            rd_addr = next_tbl[ADDR_W-1:0] + ADDR_W'(level_slice(va_reg, level_inc));
        end else begin
            rd_addr = base_reg + ADDR_W'(level_slice(va_reg, level_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_wr) begin
            store_mem[wr_addr] <= s_payload.word_value;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            va_reg    <= va_in;
            base_reg  <= root_word;
            level_reg <= first_level_reg;
        end else if (cmd.read_next) begin
            level_reg <= level_inc;
        end
        if (cmd.out_load) begin
            out_reg.leaf_descriptor <= rd_data_reg;
            out_reg.leaf_level      <= level_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ia_bits_reg     <= 6'd40;
            first_level_reg <= 2'd1;
            root_base_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IA_BITS:     ia_bits_reg     <= cfg_wdata[5:0];
                    CFG_FIRST_LEVEL: first_level_reg <= cfg_wdata[1:0];
                    CFG_ROOT_BASE:   root_base_reg   <= cfg_wdata;
                    default:         ;
                endcase
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.follow   = (level_reg != LAST_LEVEL) & rd_data_reg[0] & rd_data_reg[1];
    assign sts.out_busy = out_valid_reg & ~m_ready;

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

// ----- hdl/page_table_leaf_walker.sv -----
// Four-level, 4 KiB-granule table walker over an internal store of
// STORE_WORDS 64-bit words (power of two). An item with opcode 0 writes
// word_value at word_index (modulo the store size) as it is accepted and
// gives no result. An item with opcode 1 walks the tables for lookup_address
// and gives one result: the descriptor where the walk stopped and its level.
// A lookup holds the block while it reads 1 to 4 levels: the accepting
// cycle picks the root table, the root entry is read, each further level
// is read in turn because the registered read of the single-port table
// store must return before the next table address is known, and last the
// result register is loaded, which waits while an earlier result is still
// held. s_ready stays low from the accepting edge until that load, and
// m_valid is set by the same load. The result sits in an output register,
// so a following write or lookup is accepted while it waits for m_ready; a
// second result waits in the walker until the first is taken. Store
// contents are undefined after reset and there is no clearing pass: looking
// up through words never written gives an undefined result. The user must
// write configuration (index 0: input address bits, 1: first level, 2: root
// base) only while the block is idle; the block itself does not enforce it.
module page_table_leaf_walker
    import ptlw_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // item input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ptlw_in_t             s_payload,
    // results
    output logic                 m_valid,
    input  logic                 m_ready,
    output ptlw_out_t            m_payload
);

    ptlw_cmd_t cmd;
    ptlw_sts_t sts;

    // sequencing: idle / root read / per-level check
    ptlw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_payload.opcode),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // config regs, table store, walk registers, result register
    ptlw_datapath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // store is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.store_wr && (cmd.read_root || cmd.read_next)))
        else $error("store write overlaps walk read");

    // root read always follows the lookup setup
    a_start_then_root: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> cmd.read_root)
        else $error("root read missing after lookup start");

    // only a table descriptor is followed
    a_follow_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.read_next |-> sts.follow)
        else $error("followed a non-table descriptor");

    // a loaded result is presented next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result load not visible");

    // result register never overwritten while held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid && !m_ready))
        else $error("result overwritten before taken");

endmodule
